@@ rtl/lbp3_pkg.sv @@
// Shared types, constants and the pattern-code function of the 3x3 local binary pattern block.
// No dependencies; used by the top level and the checker.
package lbp3_pkg;

    localparam int PIXEL_W        = 8;
    localparam int CODE_W         = 8;
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int MIN_DIM        = 3;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    typedef logic [PIXEL_W-1:0]     t_pixel;
    typedef logic [CODE_W-1:0]      t_code;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_index REG_IMAGE_HEIGHT = 2'd1;

    // Neighbors in row-major order, top-left weighted highest.
    function automatic t_code lbp_code(
        input t_pixel top_left, input t_pixel top, input t_pixel top_right,
        input t_pixel left, input t_pixel center, input t_pixel right,
        input t_pixel bottom_left, input t_pixel bottom, input t_pixel bottom_right
    );
        t_code code;
        code[7] = (top_left >= center);
        code[6] = (top >= center);
        code[5] = (top_right >= center);
        code[4] = (left >= center);
        code[3] = (right >= center);
        code[2] = (bottom_left >= center);
        code[1] = (bottom >= center);
        code[0] = (bottom_right >= center);
        return code;
    endfunction

endpackage

@@ rtl/lbp3_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lbp3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/local_binary_pattern_3x3.sv @@
// 3x3 local binary pattern over a raster pixel stream; uses lbp3_pkg and lbp3_ram.
// A pixel's code passes stage 1, then the output register; one pixel per cycle unless stalled.
// The rate is set by the single line-store RAM, read at acceptance and written from stage 1.
// Synchronous active-low reset clears counters, window and valid flags and restores the
// register defaults; the line stores are not cleared and need no clearing pass.
module local_binary_pattern_3x3
    import lbp3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [PIXEL_W-1:0]        i_pixel,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CODE_W-1:0]         o_pattern_code,
    output logic                      o_last
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (WW_RAW > IMAGE_WIDTH_W) ? WW_RAW : IMAGE_WIDTH_W;

    logic [IMAGE_WIDTH_W-1:0]  r_image_width;
    logic [IMAGE_HEIGHT_W-1:0] r_image_height;
    logic [CW-1:0]             r_col;
    logic [IMAGE_HEIGHT_W-1:0] r_row;
    logic [CW-1:0]             n_col;
    logic [IMAGE_HEIGHT_W-1:0] n_row;

    logic                      r_s1_valid;
    t_pixel                    r_s1_pixel;
    logic                      r_s1_emit;
    logic                      r_s1_last;
    logic [CW-1:0]             r_s1_addr;
    t_pixel                    r_win [6];

    logic                      r_out_valid;
    t_code                     r_out_code;
    logic                      r_out_last;

    logic [WW-1:0]             w_ext;
    logic [WW-1:0]             w_eff;
    logic [CW-1:0]             w_last;
    logic [IMAGE_HEIGHT_W-1:0] h_last;
    logic                      in_accept;
    logic                      out_free;
    logic                      s1_go;
    logic                      s1_fire;
    logic                      cfg_hit;
    logic [2*PIXEL_W-1:0]      ram_rdata;
    t_pixel                    top_px;
    t_pixel                    mid_px;

    always_comb begin
        w_ext = WW'(r_image_width);
        if (w_ext < WW'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        w_last = CW'(w_eff - WW'(1));
        if (r_image_height < IMAGE_HEIGHT_W'(MIN_DIM)) begin
            h_last = IMAGE_HEIGHT_W'(MIN_DIM - 1);
        end else begin
            h_last = r_image_height - IMAGE_HEIGHT_W'(1);
        end
    end

    assign out_free  = !r_out_valid || i_ready;
    assign s1_go     = !r_s1_emit || out_free;
    assign s1_fire   = r_s1_valid && s1_go;
    assign o_ready   = !r_s1_valid || s1_go;
    assign in_accept = i_valid && o_ready;

    always_comb begin
        case (i_cfg_index)
            REG_IMAGE_WIDTH:  cfg_hit = i_cfg_we;
            REG_IMAGE_HEIGHT: cfg_hit = i_cfg_we;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_accept) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + IMAGE_HEIGHT_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // Each entry holds the upper row in the high byte and the middle row in the low byte.
    lbp3_ram #(
        .WIDTH(2 * PIXEL_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_addr),
        .i_wdata ({mid_px, r_s1_pixel}),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign top_px = ram_rdata[2*PIXEL_W-1:PIXEL_W];
    assign mid_px = ram_rdata[PIXEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IMAGE_WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IMAGE_HEIGHT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_fire) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top_px;
                r_win[4] <= mid_px;
                r_win[5] <= r_s1_pixel;
            end
            if (out_free) begin
                r_out_valid <= s1_fire && r_s1_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_addr  <= r_col;
            r_s1_emit  <= (r_row >= IMAGE_HEIGHT_W'(2)) && (r_col >= CW'(2));
            r_s1_last  <= (r_row == h_last) && (r_col == w_last);
        end
        if (out_free && s1_fire) begin
            r_out_code <= lbp_code(r_win[0], r_win[3], top_px,
                                   r_win[1], r_win[4], mid_px,
                                   r_win[2], r_win[5], r_s1_pixel);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pattern_code = r_out_code;
    assign o_last         = r_out_last;

endmodule

@@ rtl/lbp3_checker.sv @@
// Port-level checks for the 3x3 local binary pattern block, bound to its top level.
// Depends on lbp3_pkg for field widths.
module lbp3_checker
    import lbp3_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [CODE_W-1:0]      o_pattern_code,
    input logic                   o_last
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pattern_code) && $stable(o_last))
        else $error("result changed while stalled");

    // Input back-pressure comes only from a stalled result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a stalled result");

    // A fresh result follows an input transaction through stage 1 and the output register.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result appeared without a matching input transaction");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind local_binary_pattern_3x3 lbp3_checker u_lbp3_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pattern_code (o_pattern_code),
    .o_last         (o_last)
);

@@ tb/testbench.sv @@
// Self-checking testbench for local_binary_pattern_3x3: streams raster frames of several sizes
// and compares every pattern code and frame-end flag with an internal line-store predictor.
// Depends on lbp3_pkg and the local_binary_pattern_3x3 RTL.
module testbench
    import lbp3_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH    = 1024;
    localparam int IDLE_PERCENT  = 13;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;

    localparam t_cfg_index REG_SPARE_A = 2'd2;
    localparam t_cfg_index REG_SPARE_B = 2'd3;

    typedef enum {TEX_UNIFORM, TEX_NARROW, TEX_BINARY} t_texture;

    typedef struct packed {
        t_code pattern_code;
        logic  last;
    } t_code_result;

    // Three 3x3 frames: a flat frame, a bright center, and a mid-gray center.
    localparam t_pixel DIRECTED_FRAMES [27] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd255, 8'd254, 8'd255, 8'd254, 8'd255, 8'd254, 8'd255, 8'd254, 8'd255,
        8'd0,   8'd255, 8'd0,   8'd255, 8'd128, 8'd128, 8'd0,   8'd255, 8'd127
    };

    class code_scoreboard;
        bit [PIXEL_W-1:0]        upper_row [LINE_DEPTH];
        bit [PIXEL_W-1:0]        middle_row [LINE_DEPTH];
        bit [PIXEL_W-1:0]        window [6];
        logic [IMAGE_WIDTH_W-1:0]  width_reg;
        logic [IMAGE_HEIGHT_W-1:0] height_reg;
        int unsigned             col;
        int unsigned             row;
        t_code_result            expected_codes [$];
        int                      errors;

        function new();
            width_reg  = IMAGE_WIDTH_RESET;
            height_reg = IMAGE_HEIGHT_RESET;
            col        = 0;
            row        = 0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_index index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_IMAGE_WIDTH: begin
                    width_reg = data[IMAGE_WIDTH_W-1:0];
                    col = 0;
                    row = 0;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = data[IMAGE_HEIGHT_W-1:0];
                    col = 0;
                    row = 0;
                end
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pixel p);
            int unsigned  w;
            int unsigned  h;
            int unsigned  c;
            int unsigned  r;
            t_pixel       top;
            t_pixel       mid;
            t_pixel       center;
            t_code_result res;
            w = (width_reg < MIN_DIM) ? MIN_DIM :
                (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
            h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
            c = (col >= w) ? w - 1 : col;
            r = (row >= h) ? h - 1 : row;
            top = upper_row[c];
            mid = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = p;
            if (r >= 2 && c >= 2) begin
                center = window[4];
                res.pattern_code = {window[0] >= center, window[3] >= center, top >= center,
                                    window[1] >= center, mid >= center,
                                    window[2] >= center, window[5] >= center, p >= center};
                res.last = (r == h - 1) && (c == w - 1);
                expected_codes = {expected_codes, res};
            end
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top;
            window[4] = mid;
            window[5] = p;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) begin
                    r = 0;
                end
            end
            col = c;
            row = r;
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_code(t_code code, logic last);
            t_code_result exp;
            if (expected_codes.size() == 0) begin
                report($sformatf("unexpected code %02h last %0b", code, last));
            end else begin
                exp = expected_codes.pop_front();
                if (code !== exp.pattern_code) begin
                    report($sformatf("code %02h, expected %02h", code, exp.pattern_code));
                end
                if (last !== exp.last) begin
                    report($sformatf("last %0b, expected %0b", last, exp.last));
                end
            end
        endtask
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic                   o_ready;
    logic [PIXEL_W-1:0]     i_pixel     = '0;
    logic                   o_valid;
    logic                   i_ready     = 1'b0;
    logic [CODE_W-1:0]      o_pattern_code;
    logic                   o_last;

    code_scoreboard board;
    bit             calm = 1'b0;
    int unsigned    cycle_count = 0;

    local_binary_pattern_3x3 #(
        .MAX_WIDTH(LINE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pattern_code (o_pattern_code),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_code(o_pattern_code, o_last);
        end
    end

    task automatic write_reg(t_cfg_index index, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(index, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(t_pixel p);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (!o_ready);
        board.note_pixel(p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel next_pixel(t_texture tex);
        case (tex)
            TEX_NARROW: return t_pixel'($urandom_range(130, 126));
            TEX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:    return t_pixel'($urandom_range(255));
        endcase
    endfunction

    task automatic set_size(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data);
        if ($urandom_range(1)) begin
            write_reg(REG_IMAGE_WIDTH, w_data);
            write_reg(REG_IMAGE_HEIGHT, h_data);
        end else begin
            write_reg(REG_IMAGE_HEIGHT, h_data);
            write_reg(REG_IMAGE_WIDTH, w_data);
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data,
                             int unsigned n_pixels, t_texture tex);
        set_size(w_data, h_data);
        repeat (n_pixels) send_pixel(next_pixel(tex));
        drain();
    endtask

    task automatic random_phase();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        w = $urandom_range(12, 3);
        h = $urandom_range(6, 3);
        n = $urandom_range(2, 1) * w * h;
        if ($urandom_range(2) == 0) begin
            n += $urandom_range(w * h - 1, 1);
        end
        run_phase({5'($urandom), 11'(w)}, 16'(h), n, t_texture'($urandom_range(2)));
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_size(16'd3, 16'd3);
        foreach (DIRECTED_FRAMES[k]) send_pixel(DIRECTED_FRAMES[k]);
        drain();

        // Register values below the minimum behave as three.
        run_phase(16'd0, 16'd0, 22, TEX_UNIFORM);
        run_phase(16'hF801, 16'd1, 18, TEX_BINARY);
        run_phase(16'd2, 16'd2, 20, TEX_NARROW);
        repeat (3) random_phase();

        // A frame interrupted by a full drain and writes to the two unused register indices.
        set_size(16'd7, 16'd5);
        repeat (24) send_pixel(next_pixel(TEX_UNIFORM));
        drain();
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'hFFFF);
        repeat (38) send_pixel(next_pixel(TEX_UNIFORM));
        drain();

        run_phase(16'd3, 16'hFFFF, 60, TEX_UNIFORM);

        calm = 1'b1;
        run_phase(16'd40, 16'd3, 120, TEX_UNIFORM);
        calm = 1'b0;
        run_phase(16'hFFFF, 16'd3, 20, TEX_NARROW);
        run_phase(16'd1025, 16'd4, 20, TEX_UNIFORM);

        repeat (3) random_phase();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
